>>> hw/rtl/ils_pkg.sv
// Package with shared types and constants for the indexed list store.
package ils_pkg;

  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_HEAD   = 3'd1,
    ACT_TAIL   = 3'd2,
    ACT_AT     = 3'd3,
    ACT_DELETE = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH,
    S_OUT
  } state_e;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PosWidth   = 16;
  localparam int unsigned LenWidth   = 11;
  localparam logic [ValueWidth-1:0] NotFound = '1;

endpackage

>>> hw/rtl/ils_mem.sv
// Single-port synchronous element memory with registered read data.
module ils_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrWidth = 10
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrWidth-1:0]  addr_i,
  input  logic [31:0]           wdata_i,
  output logic [31:0]           rdata_o
);
  logic [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> hw/rtl/indexed_list_store.sv
// Top level of the indexed list store.
// The block keeps an ordered list of up to CAPACITY signed 32-bit values in one
// single-port memory. Each input word carries an action, a position and a value;
// each one produces exactly one output word with the read value, a found flag,
// a status code and the length after the action.
// Input and output channels use valid and stall; a word moves at an edge where
// valid is high and stall is low.
// A read passes through a wait and a finish state to the output register. An insert
// or delete shifts the entries between the position and the end of the list,
// one moved entry at a time, each read and then written back through the single
// memory port; an insert writes the new value in the finish state. Out-of-range,
// full and unused-action cases go from idle straight to the output register.
// One word is in work at a time; the input is stalled until the output word
// has been taken. While the receiver stalls, the output word holds.
// Reset empties the list at once; memory contents need no clearing.
module indexed_list_store #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 action_i,
  input  logic [15:0]                position_i,
  input  logic signed [31:0]         value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [31:0]         read_value_o,
  output logic                       found_o,
  output logic [1:0]                 status_o,
  output logic [10:0]                length_o
);
  import ils_pkg::*;

  localparam int unsigned AddrWidth = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntWidth  = $clog2(CAPACITY + 1);

  state_e state_q, state_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic [CntWidth-1:0] ptr_q, ptr_d;
  logic [CntWidth-1:0] pos_q, pos_d;
  logic [2:0]          act_q, act_d;
  logic [31:0]         val_q, val_d;
  logic [31:0]         rv_q, rv_d;
  logic                found_q, found_d;
  logic [1:0]          status_q, status_d;

  logic                mem_we;
  logic [AddrWidth-1:0] mem_addr;
  logic [31:0]         mem_wdata, mem_rdata;

  ils_mem #(.Depth(CAPACITY), .AddrWidth(AddrWidth)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  logic [16:0] pos_ext, cnt_ext;
  assign pos_ext = {1'b0, position_i};
  assign cnt_ext = 17'(count_q);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    pos_d    = pos_q;
    act_d    = act_q;
    val_d    = val_q;
    rv_d     = rv_q;
    found_d  = found_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d    = action_i;
          val_d    = value_i;
          rv_d     = NotFound;
          found_d  = 1'b0;
          status_d = ST_DONE;
          pos_d    = position_i[CntWidth-1:0];
          state_d  = S_OUT;
          case (action_e'(action_i))
            ACT_READ: begin
              if (pos_ext < cnt_ext) state_d = S_RDWAIT;
              else status_d = ST_RANGE;
            end
            ACT_HEAD, ACT_TAIL, ACT_AT: begin
              if (action_e'(action_i) == ACT_HEAD) pos_d = '0;
              if (action_e'(action_i) == ACT_TAIL) pos_d = count_q;
              if (action_e'(action_i) == ACT_AT && pos_ext > cnt_ext) begin
                status_d = ST_RANGE;
              end else if (count_q == CntWidth'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                ptr_d   = count_q;
                state_d = S_SHIFT_RD;
              end
            end
            ACT_DELETE: begin
              if (pos_ext < cnt_ext) begin
                ptr_d   = position_i[CntWidth-1:0];
                state_d = S_SHIFT_RD;
              end else begin
                status_d = ST_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDWAIT: state_d = S_FINISH;
      S_SHIFT_RD: begin
        if (act_q == ACT_DELETE) begin
          if (ptr_q + 1'b1 >= count_q) state_d = S_FINISH;
          else state_d = S_SHIFT_WR;
        end else begin
          if (ptr_q == pos_q) state_d = S_FINISH;
          else state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        if (act_q == ACT_DELETE) ptr_d = ptr_q + 1'b1;
        else ptr_d = ptr_q - 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_FINISH: begin
        case (action_e'(act_q))
          ACT_READ: begin
            rv_d    = mem_rdata;
            found_d = 1'b1;
          end
          ACT_DELETE: count_d = count_q - 1'b1;
          default:    count_d = count_q + 1'b1;
        endcase
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory port: shifts read the neighbor, then write it into the current entry.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = mem_rdata;
    case (state_q)
      S_IDLE:   mem_addr = position_i[AddrWidth-1:0];
      S_RDWAIT: mem_addr = pos_q[AddrWidth-1:0];
      S_SHIFT_RD: begin
        if (act_q == ACT_DELETE) mem_addr = AddrWidth'(ptr_q + 1'b1);
        else mem_addr = AddrWidth'(ptr_q - 1'b1);
      end
      S_SHIFT_WR: begin
        mem_we   = 1'b1;
        mem_addr = ptr_q[AddrWidth-1:0];
      end
      S_FINISH: begin
        mem_addr = pos_q[AddrWidth-1:0];
        if (act_q != ACT_READ && act_q != ACT_DELETE) begin
          mem_we    = 1'b1;
          mem_wdata = val_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    pos_q    <= pos_d;
    act_q    <= act_d;
    val_q    <= val_d;
    rv_q     <= rv_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign read_value_o = rv_q;
  assign found_o      = found_q;
  assign status_o     = status_q;
  assign length_o     = 11'(count_q);
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the indexed list store: list operations against a queue model.
module tb_top;
  import ils_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = 1024;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic [1:0]         status;
    logic [10:0]        length;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] action_i = '0;
  logic [15:0] position_i = '0;
  logic signed [31:0] value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] read_value_o;
  logic found_o;
  logic [1:0] status_o;
  logic [10:0] length_o;

  logic signed [31:0] list_model[$];
  result_t expected_q[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int idle_cycles = 0;
  bit hold_receiver = 1'b0;
  bit quiet_stall = 1'b0;

  always #5 clk_i = ~clk_i;

  indexed_list_store #(.CAPACITY(Cap)) i_dut (.*);

  function automatic result_t predict_list_op(logic [2:0] act, logic [15:0] pos,
                                              logic signed [31:0] val);
    result_t r;
    int unsigned len;
    int unsigned at;
    len = list_model.size();
    r.read_value = NotFound;
    r.found = 1'b0;
    r.status = ST_DONE;
    at = 32'(pos);
    if (act == ACT_HEAD) at = 0;
    if (act == ACT_TAIL) at = len;
    case (act)
      ACT_READ: begin
        if (pos < len) begin
          r.read_value = list_model[pos];
          r.found = 1'b1;
        end else begin
          r.status = ST_RANGE;
        end
      end
      ACT_HEAD, ACT_TAIL, ACT_AT: begin
        if (at > len) r.status = ST_RANGE;
        else if (len >= Cap) r.status = ST_FULL;
        else list_model.insert(at, val);
      end
      ACT_DELETE: begin
        if (pos < len) list_model.delete(pos);
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    r.length = 11'(list_model.size());
    return r;
  endfunction

  task automatic send_word(logic [2:0] act, logic [15:0] pos, logic signed [31:0] val);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(posedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= act;
    position_i <= pos;
    value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_list_op(act, pos, val));
    words_sent++;
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_pos();
    int unsigned len;
    len = list_model.size();
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1: return 16'(len);
      2: return 16'(len + 1);
      default: return (len == 0) ? 16'd0 : 16'($urandom_range(0, len - 1));
    endcase
  endfunction

  task automatic test_directed();
    send_word(ACT_READ, 16'd0, 32'sd5);
    send_word(ACT_DELETE, 16'd0, 32'sd0);
    send_word(ACT_AT, 16'd1, 32'sd7);
    send_word(ACT_AT, 16'hFFFF, 32'sd7);
    send_word(ACT_HEAD, 16'hFFFF, 32'h7FFF_FFFF);
    send_word(ACT_TAIL, 16'd0, 32'h8000_0000);
    send_word(ACT_AT, 16'd2, 32'hFFFF_FFFF);
    send_word(ACT_AT, 16'd0, 32'h0000_0000);
    send_word(ACT_AT, 16'd2, 32'h5555_AAAA);
    for (int i = 0; i < 5; i++) send_word(ACT_READ, 16'(i), 32'sd0);
    send_word(ACT_READ, 16'hFFFF, 32'sd0);
    send_word(3'd5, 16'd0, 32'sd1);
    send_word(3'd6, 16'hFFFF, 32'sd1);
    send_word(3'd7, 16'd1, 32'sd1);
    send_word(ACT_DELETE, 16'd4, 32'sd0);
    send_word(ACT_DELETE, 16'd0, 32'sd0);
    send_word(ACT_DELETE, 16'd1, 32'sd0);
    send_word(ACT_DELETE, 16'hFFFF, 32'sd0);
    send_word(ACT_READ, 16'd0, 32'sd0);
    wait_drained();
  endtask

  task automatic test_random_mix(int count);
    logic [2:0] act;
    for (int i = 0; i < count; i++) begin
      act = 3'($urandom_range(0, 4));
      if ($urandom_range(0, 19) == 0) act = 3'($urandom_range(5, 7));
      send_word(act, rand_pos(), $urandom());
    end
  endtask

  task automatic test_receiver_hold();
    fork
      begin
        hold_receiver = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_receiver = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_word(ACT_TAIL, 16'd0, $urandom());
    join
    wait_drained();
  endtask

  task automatic test_long_shifts();
    // The list is grown at the tail, then shifted over its whole length from the head.
    quiet_stall = 1'b1;
    while (list_model.size() < 160) send_word(ACT_TAIL, 16'd0, $urandom());
    send_word(ACT_AT, 16'd0, 32'sd1);
    send_word(ACT_HEAD, 16'd0, 32'sd2);
    send_word(ACT_READ, 16'd0, 32'sd0);
    send_word(ACT_READ, 16'(list_model.size() - 1), 32'sd0);
    send_word(ACT_DELETE, 16'd0, 32'sd0);
    send_word(ACT_AT, 16'(list_model.size() + 1), 32'sd1);
    send_word(ACT_READ, 16'(list_model.size()), 32'sd0);
    while (list_model.size() > 8) send_word(ACT_DELETE, 16'(list_model.size() - 1), 32'sd0);
    quiet_stall = 1'b0;
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_receiver) out_stall_i <= 1'b1;
    else if (quiet_stall) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected output word");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        words_checked++;
        if (read_value_o !== exp_r.read_value) begin
          $error("read_value: expected %0d, got %0d", exp_r.read_value, read_value_o);
          errors++;
        end
        if (found_o !== exp_r.found) begin
          $error("found: expected %0b, got %0b", exp_r.found, found_o);
          errors++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          errors++;
        end
        if (length_o !== exp_r.length) begin
          $error("length: expected %0d, got %0d", exp_r.length, length_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_receiver)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d words outstanding", expected_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_receiver_hold();
    test_random_mix(150);
    wait_drained();
    test_long_shifts();
    test_random_mix(150);
    wait_drained();
    repeat (2200) @(posedge clk_i);
    $display("Sent %0d words, checked %0d results.", words_sent, words_checked);
    $display("Covered reads, head, tail and positional inserts, long shifts, deletes and unused codes.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
